/* rtl/ssr_pkg.sv */
// ssr_pkg: shared types, codes and microcode table of the substring replacer
package ssr_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_PATTERN_BYTES      = 3'd0;
   localparam logic [2:0] CSR_PATTERN_LENGTH     = 3'd1;
   localparam logic [2:0] CSR_REPLACEMENT_BYTES  = 3'd2;
   localparam logic [2:0] CSR_REPLACEMENT_LENGTH = 3'd3;

   // input transaction payload
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_payload_type;

   // result transaction payload
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       text_done;
      logic       run_last;
   } rsp_payload_type;

   // sequencer step addresses
   typedef enum logic [2:0] {
      STEP_WAIT,
      STEP_FLUSH,
      STEP_MARK,
      STEP_PASS,
      STEP_CHECK,
      STEP_MATCH,
      STEP_REPL
   } step_type;

   // jump conditions
   typedef enum logic [2:0] {
      COND_DISPATCH,
      COND_NEVER,
      COND_HELD_EMPTY,
      COND_PREFIX,
      COND_NOT_FULL,
      COND_REPL_DONE
   } cond_type;

   // result source
   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_HELD,
      EMIT_INPUT,
      EMIT_REPL,
      EMIT_MARK
   } emit_type;

   // how run_last is formed
   typedef enum logic [1:0] {
      LAST_NEVER,
      LAST_ALWAYS,
      LAST_POP,
      LAST_REPL
   } last_type;

   // one control word: jump when cond holds, else do the action and go to next_step
   typedef struct packed {
      cond_type cond;
      step_type jump_step;
      emit_type emit;
      logic     pop;
      logic     clear;
      last_type last;
      step_type next_step;
   } ucode_word_type;

   // microcode table
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      w = '{COND_DISPATCH, STEP_WAIT, EMIT_NONE, 1'b0, 1'b0, LAST_NEVER, STEP_WAIT};
      unique case (step)
         STEP_WAIT:  w = '{COND_DISPATCH, STEP_WAIT, EMIT_NONE, 1'b0, 1'b0,
                           LAST_NEVER, STEP_WAIT};
         STEP_FLUSH: w = '{COND_HELD_EMPTY, STEP_MARK, EMIT_HELD, 1'b1, 1'b0,
                           LAST_NEVER, STEP_FLUSH};
         STEP_MARK:  w = '{COND_NEVER, STEP_WAIT, EMIT_MARK, 1'b0, 1'b0,
                           LAST_ALWAYS, STEP_WAIT};
         STEP_PASS:  w = '{COND_NEVER, STEP_WAIT, EMIT_INPUT, 1'b0, 1'b0,
                           LAST_ALWAYS, STEP_WAIT};
         STEP_CHECK: w = '{COND_PREFIX, STEP_MATCH, EMIT_HELD, 1'b1, 1'b0,
                           LAST_POP, STEP_CHECK};
         STEP_MATCH: w = '{COND_NOT_FULL, STEP_WAIT, EMIT_NONE, 1'b0, 1'b1,
                           LAST_NEVER, STEP_REPL};
         STEP_REPL:  w = '{COND_REPL_DONE, STEP_WAIT, EMIT_REPL, 1'b0, 1'b0,
                           LAST_REPL, STEP_REPL};
         default:    w = '{COND_DISPATCH, STEP_WAIT, EMIT_NONE, 1'b0, 1'b0,
                           LAST_NEVER, STEP_WAIT};
      endcase
      return w;
   endfunction

   // byte i of a packed 64-bit word, first byte in bits 7:0
   function automatic logic [7:0] byte_of(input logic [63:0] word, input logic [2:0] idx);
      return word[{idx, 3'b000} +: 8];
   endfunction

endpackage

/* rtl/stream_substring_replacer.sv */
// stream_substring_replacer: microcoded find-and-replace-all over a byte stream
// The accepted input sets the sequencer step, which then loads the result register. Input
// stalls until the sequencer is back in wait; each result takes its own sequencer step, a byte
// extending a partial match passes the check and match steps, a full match goes on to the
// replace step, end of text to the closing-marker step. Result steps wait while output is stalled.
// Reset (synchronous): sequencer to wait, held count, output valid and config cleared.
module stream_substring_replacer #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ssr_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ssr_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [63:0]              csr_data
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam logic [3:0] MAX_LEN = 4'(MAX_PATTERN);

   // configuration registers
   logic [63:0] pattern_bytes_ff;
   logic [3:0]  pattern_length_ff;
   logic [63:0] replacement_bytes_ff;
   logic [3:0]  replacement_length_ff;

   // sequencer and datapath state
   ssr_pkg::step_type        step_ff, step_in;
   logic [7:0]               held_ff [MAX_PATTERN];
   logic [CNT_W-1:0]         held_count_ff;
   logic [CNT_W-1:0]         repl_idx_ff;
   logic [7:0]               in_byte_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   ssr_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   ssr_pkg::ucode_word_type  uword;
   logic [3:0]               plen4, rlen4;
   logic [CNT_W-1:0]         plen, rlen;
   logic                     held_prefix, shifted_prefix;
   logic                     cond_true, out_free, step_go, do_action;
   logic                     req_accept, csr_write, append;

   assign req_stall  = (step_ff != ssr_pkg::STEP_WAIT);
   assign csr_ready  = (step_ff == ssr_pkg::STEP_WAIT);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // saturated lengths
   assign plen4 = (pattern_length_ff > MAX_LEN) ? MAX_LEN : pattern_length_ff;
   assign rlen4 = (replacement_length_ff > MAX_LEN) ? MAX_LEN : replacement_length_ff;
   assign plen  = CNT_W'(plen4);
   assign rlen  = CNT_W'(rlen4);

   assign append = req_accept && !req_payload.end_of_text && (plen != '0);

   // prefix checks of the held run and of the run after dropping its oldest byte
   always_comb begin
      held_prefix    = 1'b1;
      shifted_prefix = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((CNT_W'(i) < held_count_ff) &&
             (held_ff[i] != ssr_pkg::byte_of(pattern_bytes_ff, 3'(i)))) begin
            held_prefix = 1'b0;
         end
      end
      for (int i = 0; i + 1 < MAX_PATTERN; i++) begin
         if ((CNT_W'(i + 1) < held_count_ff) &&
             (held_ff[i + 1] != ssr_pkg::byte_of(pattern_bytes_ff, 3'(i)))) begin
            shifted_prefix = 1'b0;
         end
      end
   end

   // control word fetch and condition evaluation
   always_comb begin
      uword    = ssr_pkg::ucode_rom(step_ff);
      out_free = !rsp_valid_ff || !rsp_stall;
      case (uword.cond)
         ssr_pkg::COND_HELD_EMPTY: cond_true = (held_count_ff == '0);
         ssr_pkg::COND_PREFIX:     cond_true = held_prefix;
         ssr_pkg::COND_NOT_FULL:   cond_true = (held_count_ff != plen);
         ssr_pkg::COND_REPL_DONE:  cond_true = (repl_idx_ff == rlen);
         default:                  cond_true = 1'b0;
      endcase
      step_go   = cond_true || (uword.emit == ssr_pkg::EMIT_NONE) || out_free;
      do_action = (uword.cond != ssr_pkg::COND_DISPATCH) && !cond_true && step_go;
   end

   // next step
   always_comb begin
      step_in = step_ff;
      if (uword.cond == ssr_pkg::COND_DISPATCH) begin
         if (req_accept) begin
            if (req_payload.end_of_text) begin
               step_in = ssr_pkg::STEP_FLUSH;
            end else if (plen == '0) begin
               step_in = ssr_pkg::STEP_PASS;
            end else begin
               step_in = ssr_pkg::STEP_CHECK;
            end
         end
      end else if (cond_true) begin
         step_in = uword.jump_step;
      end else if (step_go) begin
         step_in = uword.next_step;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (do_action && (uword.emit != ssr_pkg::EMIT_NONE)) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.byte_valid = 1'b1;
         rsp_payload_in.text_done  = 1'b0;
         case (uword.emit)
            ssr_pkg::EMIT_HELD:  rsp_payload_in.out_byte = held_ff[0];
            ssr_pkg::EMIT_INPUT: rsp_payload_in.out_byte = in_byte_ff;
            ssr_pkg::EMIT_REPL:  rsp_payload_in.out_byte =
                                    ssr_pkg::byte_of(replacement_bytes_ff, 3'(repl_idx_ff));
            default: begin
               rsp_payload_in.out_byte   = 8'd0;
               rsp_payload_in.byte_valid = 1'b0;
               rsp_payload_in.text_done  = 1'b1;
            end
         endcase
         case (uword.last)
            ssr_pkg::LAST_ALWAYS: rsp_payload_in.run_last = 1'b1;
            ssr_pkg::LAST_POP:    rsp_payload_in.run_last = shifted_prefix;
            ssr_pkg::LAST_REPL:   rsp_payload_in.run_last = (repl_idx_ff + 1'b1 == rlen);
            default:              rsp_payload_in.run_last = 1'b0;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ssr_pkg::STEP_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= '0;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            ssr_pkg::CSR_PATTERN_BYTES:      pattern_bytes_ff      <= csr_data;
            ssr_pkg::CSR_PATTERN_LENGTH:     pattern_length_ff     <= csr_data[3:0];
            ssr_pkg::CSR_REPLACEMENT_BYTES:  replacement_bytes_ff  <= csr_data;
            ssr_pkg::CSR_REPLACEMENT_LENGTH: replacement_length_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // held count and replacement index
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
         repl_idx_ff   <= '0;
      end else begin
         if (csr_write && ((csr_index == ssr_pkg::CSR_PATTERN_BYTES) ||
                           (csr_index == ssr_pkg::CSR_PATTERN_LENGTH))) begin
            held_count_ff <= '0;
         end else if (append) begin
            held_count_ff <= held_count_ff + 1'b1;
         end else if (do_action && uword.clear) begin
            held_count_ff <= '0;
         end else if (do_action && uword.pop) begin
            held_count_ff <= held_count_ff - 1'b1;
         end
         if (do_action && uword.clear) begin
            repl_idx_ff <= '0;
         end else if (do_action && (uword.emit == ssr_pkg::EMIT_REPL)) begin
            repl_idx_ff <= repl_idx_ff + 1'b1;
         end
      end
   end

   // held run: append at the tail, shift out the oldest byte
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_payload.text_byte;
      end
      if (append) begin
         held_ff[held_count_ff[IDX_W-1:0]] <= req_payload.text_byte;
      end else if (do_action && uword.pop) begin
         for (int i = 0; i + 1 < MAX_PATTERN; i++) begin
            held_ff[i] <= held_ff[i + 1];
         end
      end
   end

endmodule

/* rtl/ssr_checker.sv */
// ssr_checker: port-level assertions for the substring replacer, bound to the top level
module ssr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input ssr_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input ssr_pkg::rsp_payload_type rsp_payload,
   input logic                     csr_ready
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // closing marker carries no byte and ends its run
   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.text_done |-> rsp_payload.run_last && !rsp_payload.byte_valid)
      else $error("malformed closing marker");

   // config port and input side open together
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready == !req_stall)
      else $error("config port open while busy");

   // an end marker transaction always keeps the block busy for its flush
   a_eot_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.end_of_text |=> req_stall)
      else $error("end of text not flushed");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stream_substring_replacer ssr_checker u_ssr_checker (.*);

/* tb/tb.sv */
// tb: self-checking testbench of the stream substring replacer
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAT      = 8;
   localparam int LIMIT_CYCLES = 2000000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 20;
   localparam int RANDOM_ITEMS = 480;
   // register indexes the block does not decode
   localparam logic [2:0] CSR_NONE_LO = 3'd4;
   localparam logic [2:0] CSR_NONE_HI = 3'd7;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   ssr_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   ssr_pkg::rsp_payload_type rsp_payload;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [2:0]               csr_index = ssr_pkg::CSR_PATTERN_BYTES;
   logic [63:0]              csr_data = '0;

   stream_substring_replacer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor copy of configuration and match state
   logic [63:0]     cfg_pattern = '0;
   logic [63:0]     cfg_replacement = '0;
   logic [3:0]      cfg_pattern_len = '0;
   logic [3:0]      cfg_replacement_len = '0;
   logic [7:0]      held [MAX_PAT];
   int              held_count = 0;

   ssr_pkg::rsp_payload_type expected_text [$];
   ssr_pkg::req_payload_type text_queue [$];
   int              error_count = 0;
   int              sent_items = 0;
   int              cycle_count = 0;
   logic            req_took = 1'b0;
   bit              quiet = 1'b0;
   bit              hold_go = 1'b0;
   bit              hold_seen = 1'b0;
   int              stall_left = 0;
   int              send_gap = 0;

   function automatic logic [7:0] byte_at(input logic [63:0] w, input int i);
      return w[i*8 +: 8];
   endfunction

   // held run is still a prefix of the pattern
   function automatic bit held_is_pattern_prefix(input int plen);
      int i;
      if (held_count > plen) return 1'b0;
      for (i = 0; i < held_count; i++)
         if (held[i] != byte_at(cfg_pattern, i)) return 1'b0;
      return 1'b1;
   endfunction

   task automatic push_expected(input logic [7:0] b, input logic v, input logic d);
      ssr_pkg::rsp_payload_type e;
      e.out_byte   = b;
      e.byte_valid = v;
      e.text_done  = d;
      e.run_last   = 1'b0;
      expected_text.push_back(e);
   endtask

   // expected output bytes of one input transaction
   task automatic predict_replace(input ssr_pkg::req_payload_type item);
      int                       plen, rlen, n0, i;
      ssr_pkg::rsp_payload_type tail;
      plen = (cfg_pattern_len > MAX_PAT) ? MAX_PAT : int'(cfg_pattern_len);
      rlen = (cfg_replacement_len > MAX_PAT) ? MAX_PAT : int'(cfg_replacement_len);
      n0 = expected_text.size();
      if (held_count > MAX_PAT - 1) held_count = 0;
      if (item.end_of_text) begin
         // flush held bytes, then the closing marker
         for (i = 0; i < held_count; i++) push_expected(held[i], 1'b1, 1'b0);
         held_count = 0;
         push_expected(8'h00, 1'b0, 1'b1);
      end else if (plen == 0) begin
         push_expected(item.text_byte, 1'b1, 1'b0);
      end else begin
         held[held_count] = item.text_byte;
         held_count++;
         // naive rescan: drop the oldest byte until the run is a prefix again
         while (held_count > 0 && !held_is_pattern_prefix(plen)) begin
            push_expected(held[0], 1'b1, 1'b0);
            for (i = 0; i < MAX_PAT - 1; i++) held[i] = held[i+1];
            held_count--;
         end
         if (held_count == plen) begin
            for (i = 0; i < rlen; i++) push_expected(byte_at(cfg_replacement, i), 1'b1, 1'b0);
            held_count = 0;
         end
      end
      if (expected_text.size() > n0) begin
         tail = expected_text.pop_back();
         tail.run_last = 1'b1;
         expected_text.push_back(tail);
      end
   endtask

   // monitor: register writes, result check, input prediction
   always @(posedge clock) begin : monitor
      ssr_pkg::rsp_payload_type want;
      if (reset) begin
         req_took <= 1'b0;
         cfg_pattern = '0;
         cfg_replacement = '0;
         cfg_pattern_len = '0;
         cfg_replacement_len = '0;
         held_count = 0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ssr_pkg::CSR_PATTERN_BYTES: begin
                  cfg_pattern = csr_data;
                  held_count = 0;
               end
               ssr_pkg::CSR_PATTERN_LENGTH: begin
                  cfg_pattern_len = csr_data[3:0];
                  held_count = 0;
               end
               ssr_pkg::CSR_REPLACEMENT_BYTES:  cfg_replacement = csr_data;
               ssr_pkg::CSR_REPLACEMENT_LENGTH: cfg_replacement_len = csr_data[3:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $error("unexpected result transaction: out_byte %0h", rsp_payload.out_byte);
               error_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_payload.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, actual %0h", want.out_byte,
                         rsp_payload.out_byte);
                  error_count++;
               end
               if (rsp_payload.byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %0b, actual %0b", want.byte_valid,
                         rsp_payload.byte_valid);
                  error_count++;
               end
               if (rsp_payload.text_done !== want.text_done) begin
                  $error("text_done: expected %0b, actual %0b", want.text_done,
                         rsp_payload.text_done);
                  error_count++;
               end
               if (rsp_payload.run_last !== want.run_last) begin
                  $error("run_last: expected %0b, actual %0b", want.run_last,
                         rsp_payload.run_last);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) predict_replace(req_payload);
      end
   end

   // driver: input transactions from the pending queue with random gaps
   always @(negedge clock) begin : driver
      int r;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (req_valid && !req_took) begin
         // stalled, hold the payload
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (text_queue.size() > 0) begin
         req_payload <= text_queue.pop_front();
         req_valid <= 1'b1;
         r = $urandom_range(0, 99);
         if (quiet || r < 70) send_gap = 0;
         else if (r < 95) send_gap = $urandom_range(1, 3);
         else send_gap = $urandom_range(10, 40);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall, with a long hold-off on request
   always @(negedge clock) begin : receiver
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_go && !hold_seen) stall_left = HOLD_CYCLES;
         hold_seen = hold_go;
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic push_item(input logic [7:0] b, input logic eot);
      ssr_pkg::req_payload_type it;
      it.text_byte   = b;
      it.end_of_text = eot;
      text_queue.push_back(it);
      sent_items++;
   endtask

   // one text built from pattern pieces, near-miss bytes and noise
   task automatic push_text(input logic [23:0] alpha, input logic [63:0] pat,
                            input int plen, input int chunks, input bit close);
      int c, k, len, r;
      for (c = 0; c < chunks; c++) begin
         r = $urandom_range(0, 99);
         if (plen > 0 && r < 35) begin
            for (k = 0; k < plen; k++) push_item(byte_at(pat, k), 1'b0);
         end else if (plen > 1 && r < 60) begin
            len = $urandom_range(1, plen - 1);
            for (k = 0; k < len; k++) push_item(byte_at(pat, k), 1'b0);
         end else if (r < 85) begin
            push_item(alpha[$urandom_range(0, 2)*8 +: 8], 1'b0);
         end else begin
            push_item(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      if (close) push_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic release_csr();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender pause until every expected result is in, then let the block settle
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (text_queue.size() != 0 || req_valid || expected_text.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int          phase, k, plen_w, rlen_w, plen_sat, texts;
      logic [63:0] pat_w, word;
      logic [23:0] alpha;
      bit          close;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pass-through with reset configuration, undecoded index ignored
      write_csr(CSR_NONE_LO, 64'd3);
      release_csr();
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h5A, 1'b0);
      push_item(8'hA5, 1'b1);
      wait_idle();

      // match, rescan, partial match left pending
      write_csr(ssr_pkg::CSR_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_6261);
      write_csr(ssr_pkg::CSR_PATTERN_LENGTH, 64'd2);
      write_csr(ssr_pkg::CSR_REPLACEMENT_BYTES, 64'h0000_0000_005A_5958);
      write_csr(ssr_pkg::CSR_REPLACEMENT_LENGTH, 64'd3);
      release_csr();
      push_item(8'h61, 1'b0);
      push_item(8'h62, 1'b0);
      push_item(8'h61, 1'b0);
      push_item(8'h61, 1'b0);
      push_item(8'h62, 1'b0);
      push_item(8'h61, 1'b0);
      wait_idle();

      // pattern change mid-text drops the held byte, end flushes a new one
      write_csr(ssr_pkg::CSR_PATTERN_BYTES, 64'h0000_0000_0000_6463);
      release_csr();
      push_item(8'h63, 1'b0);
      push_item(8'h64, 1'b0);
      push_item(8'h63, 1'b0);
      push_item(8'h00, 1'b1);
      wait_idle();

      // saturated pattern length, empty replacement
      write_csr(ssr_pkg::CSR_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(ssr_pkg::CSR_PATTERN_LENGTH, 64'hA5A5_A5A5_A5A5_A5AF);
      write_csr(ssr_pkg::CSR_REPLACEMENT_BYTES, 64'h0);
      write_csr(ssr_pkg::CSR_REPLACEMENT_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
      release_csr();
      for (k = 0; k < 8; k++) push_item(8'hFF, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h00, 1'b0);
      push_item(8'h7E, 1'b1);
      wait_idle();

      // random phases, each with its own configuration
      sent_items = 0;
      phase = 0;
      while (sent_items < RANDOM_ITEMS) begin
         alpha[7:0]   = 8'($urandom_range(0, 255));
         alpha[15:8]  = alpha[7:0] ^ (8'h01 << $urandom_range(0, 7));
         alpha[23:16] = 8'($urandom_range(0, 255));
         if (phase == 1) alpha = '0;
         for (k = 0; k < MAX_PAT; k++) pat_w[k*8 +: 8] = alpha[$urandom_range(0, 2)*8 +: 8];
         case (phase)
            0: plen_w = 8;
            1: plen_w = 1;
            3: plen_w = 0;
            default: begin
               k = $urandom_range(0, 9);
               if (k == 0) plen_w = 0;
               else if (k == 1) plen_w = $urandom_range(9, 15);
               else plen_w = $urandom_range(1, 8);
            end
         endcase
         case (phase)
            0: rlen_w = 8;
            4: rlen_w = 15;
            default: rlen_w = $urandom_range(0, 15);
         endcase
         plen_sat = (plen_w > MAX_PAT) ? MAX_PAT : plen_w;

         write_csr(ssr_pkg::CSR_PATTERN_BYTES, pat_w);
         word = {$urandom(), $urandom()};
         word[3:0] = 4'(plen_w);
         write_csr(ssr_pkg::CSR_PATTERN_LENGTH, word);
         write_csr(ssr_pkg::CSR_REPLACEMENT_BYTES, {$urandom(), $urandom()});
         word = {$urandom(), $urandom()};
         word[3:0] = 4'(rlen_w);
         write_csr(ssr_pkg::CSR_REPLACEMENT_LENGTH, word);
         if ($urandom_range(0, 2) == 0)
            write_csr(3'($urandom_range(CSR_NONE_HI, CSR_NONE_LO)), {$urandom(), $urandom()});
         release_csr();

         quiet = ($urandom_range(0, 3) == 0) && phase != 2;
         // long receiver hold-off while the sender keeps offering
         if (phase == 2) hold_go = 1'b1;
         texts = (phase == 2) ? 5 : 3;
         for (k = 0; k < texts; k++) begin
            close = (k < texts - 1) || ($urandom_range(0, 4) != 0);
            push_text(alpha, pat_w, plen_sat, $urandom_range(0, 8), close);
         end
         wait_idle();
         hold_go = 1'b0;
         phase++;
      end

      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
